// ===== sv/binary_heap_priority_queue_macros.svh =====
// Assertion macros for the binary heap priority queue.
// Included by the top level; needs a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BHPQ_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("bhpq assertion failed");

// Next-cycle implication, checked outside reset.
`define BHPQ_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("bhpq assertion failed");

`endif

// ===== sv/bhpq_pkg.sv =====
// Shared types, constants and the order function of the binary heap priority queue.
// No dependencies; used by bhpq_sift and the top level.
`default_nettype none

package bhpq_pkg;

    // Store geometry.
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 1;
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 9;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One result as handed from the sift engine to the output stage.
    typedef struct packed {
        logic [DATA_W-1:0]  top_value;
        logic [ENTRY_W-1:0] entry_count;
        t_status            status;
    } t_result;

    // True when a belongs above b: smaller on top in min mode, larger in max mode.
    function automatic logic wins(input logic mode, input logic [DATA_W-1:0] a,
                                  input logic [DATA_W-1:0] b);
        return mode ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
    endfunction

endpackage

`default_nettype wire

// ===== sv/bhpq_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, otherwise read into the output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bhpq_sift.sv =====
// Heap engine: fill count, root copy and the sift-up / sift-down sequencer.
// Depends on bhpq_pkg and instantiates bhpq_ram for the heap store.
`default_nettype none

module bhpq_sift (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [1:0]               i_op,
    input  wire logic [bhpq_pkg::DATA_W-1:0] i_value,
    input  wire logic                     i_mode,
    output logic                          o_idle,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output bhpq_pkg::t_result             o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [bhpq_pkg::CNT_W-1:0]      r_count;
    logic [bhpq_pkg::IDX_W-1:0]      r_pos;
    logic [bhpq_pkg::DATA_W-1:0]     r_val;
    logic [bhpq_pkg::DATA_W-1:0]     r_bval;
    logic [bhpq_pkg::IDX_W-1:0]      r_bidx;
    logic [bhpq_pkg::DATA_W-1:0]     r_root;
    bhpq_pkg::t_status               r_status;
    logic                            r_mode;

    logic                            w_we;
    logic [bhpq_pkg::IDX_W-1:0]      w_addr;
    logic [bhpq_pkg::DATA_W-1:0]     w_wdata;
    logic [bhpq_pkg::DATA_W-1:0]     w_rdata;

    logic [bhpq_pkg::IDX_W-1:0]      w_parent;
    logic [bhpq_pkg::CHILD_W-1:0]    w_left;
    logic [bhpq_pkg::CHILD_W-1:0]    w_right;
    logic [bhpq_pkg::CHILD_W-1:0]    w_cnt_ext;
    logic                            w_has_left;
    logic                            w_has_right;
    logic                            w_r_win;
    logic [bhpq_pkg::DATA_W-1:0]     w_sel_val;
    logic [bhpq_pkg::IDX_W-1:0]      w_sel_idx;
    logic                            w_full;

    // Heap store.
    bhpq_ram #(
        .WIDTH (bhpq_pkg::DATA_W),
        .DEPTH (bhpq_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Tree navigation around the current hole position.
    assign w_parent    = (r_pos - bhpq_pkg::IDX_W'(1)) >> 1;
    assign w_left      = {r_pos, 1'b1};
    assign w_right     = w_left + bhpq_pkg::CHILD_W'(1);
    assign w_cnt_ext   = bhpq_pkg::CHILD_W'(r_count);
    assign w_has_left  = w_left < w_cnt_ext;
    assign w_has_right = w_right < w_cnt_ext;
    assign w_full      = r_count == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY);

    // Winner among the hole value, the left child and the right child.
    assign w_r_win   = w_has_right && bhpq_pkg::wins(r_mode, w_rdata, r_bval);
    assign w_sel_val = w_r_win ? w_rdata : r_bval;
    assign w_sel_idx = w_r_win ? w_right[bhpq_pkg::IDX_W-1:0] : r_bidx;

    // Store access for each step; reads and writes never share a cycle.
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_pos;
        w_wdata = r_val;
        case (r_state)
            S_IDLE: begin
                // Removal fetches the last entry, which moves to the root.
                w_addr = bhpq_pkg::IDX_W'(r_count - bhpq_pkg::CNT_W'(1));
            end
            S_UP: begin
                w_we   = r_pos == '0;
                w_addr = (r_pos == '0) ? r_pos : w_parent;
            end
            S_UP_CMP: begin
                w_we    = 1'b1;
                w_wdata = bhpq_pkg::wins(r_mode, r_val, w_rdata) ? w_rdata : r_val;
            end
            S_DN: begin
                w_we   = !w_has_left;
                w_addr = w_has_left ? w_left[bhpq_pkg::IDX_W-1:0] : r_pos;
            end
            S_DN_L: begin
                w_addr = w_right[bhpq_pkg::IDX_W-1:0];
            end
            S_DN_R: begin
                w_we    = 1'b1;
                w_wdata = w_sel_val;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= bhpq_pkg::ST_OK;
        end else begin
            if (w_we && w_addr == '0) begin
                r_root <= w_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode   <= i_mode;
                        r_status <= bhpq_pkg::ST_OK;
                        r_state  <= S_DONE;
                        if (i_op == bhpq_pkg::OP_INSERT) begin
                            if (w_full) begin
                                r_status <= bhpq_pkg::ST_FULL;
                            end else begin
                                r_pos   <= bhpq_pkg::IDX_W'(r_count);
                                r_count <= r_count + bhpq_pkg::CNT_W'(1);
                                r_val   <= i_value;
                                r_state <= S_UP;
                            end
                        end else if (i_op == bhpq_pkg::OP_REMOVE) begin
                            if (r_count == '0) begin
                                r_status <= bhpq_pkg::ST_EMPTY;
                            end else begin
                                r_count <= r_count - bhpq_pkg::CNT_W'(1);
                                if (r_count != bhpq_pkg::CNT_W'(1)) begin
                                    r_state <= S_DN_LAST;
                                end
                            end
                        end
                    end
                end
                S_UP: begin
                    r_state <= (r_pos == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP: begin
                    // Parent moves down into the hole when the new value wins.
                    if (bhpq_pkg::wins(r_mode, r_val, w_rdata)) begin
                        r_pos   <= w_parent;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DN_LAST: begin
                    r_val   <= w_rdata;
                    r_pos   <= '0;
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_state <= w_has_left ? S_DN_L : S_DONE;
                end
                S_DN_L: begin
                    if (bhpq_pkg::wins(r_mode, w_rdata, r_val)) begin
                        r_bval <= w_rdata;
                        r_bidx <= w_left[bhpq_pkg::IDX_W-1:0];
                    end else begin
                        r_bval <= r_val;
                        r_bidx <= r_pos;
                    end
                    r_state <= S_DN_R;
                end
                S_DN_R: begin
                    // The winning child moves up; the hole follows it down.
                    if (w_sel_idx == r_pos) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pos   <= w_sel_idx;
                        r_state <= S_DN;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result of the finished item.
    assign o_idle               = r_state == S_IDLE;
    assign o_res_valid          = r_state == S_DONE;
    assign o_res.top_value      = (r_count == '0) ? '1 : r_root;
    assign o_res.entry_count    = bhpq_pkg::ENTRY_W'(r_count);
    assign o_res.status         = r_status;

endmodule

`default_nettype wire

// ===== sv/binary_heap_priority_queue.sv =====
// Binary heap priority queue of signed 32-bit values with min or max order.
// An insert, removal or query is one input transfer and gives one output transfer with the
// root value (-1 when empty), the entry count and a status. The heap lives in one single-port
// RAM with registered reads, so each tree level costs one RAM access per read or write.
// A query, a rejected item or the removal of the only entry goes straight to its result. Per
// level, an insert reads the parent and writes the hole, and a removal reads the left and the
// right child and writes the hole. Each item then waits while the output register stays full.
// A new item is taken once the previous result has gone into the output register.
// heap_mode resets to min order.
// Depends on bhpq_pkg, bhpq_sift, bhpq_ram and the assertion macro header.
`default_nettype none

`include "binary_heap_priority_queue_macros.svh"

module binary_heap_priority_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: heap_mode, 1 min order, 0 max order.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic [1:0]  i_s_tuser,   // [1:0] operation
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [31:0] top_value, [40:32] entry_count, [47:41] zero
    output logic [1:0]       o_m_tuser    // [1:0] status
);

    logic              r_mode;
    logic              r_m_valid;
    bhpq_pkg::t_result r_m_res;

    logic              w_idle;
    logic              w_res_valid;
    logic              w_res_ready;
    bhpq_pkg::t_result w_res;
    logic              w_in_xfer;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign o_s_tready = w_idle;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    bhpq_sift u_sift (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_xfer),
        .i_op        (i_s_tuser),
        .i_value     (i_s_tdata),
        .i_mode      (r_mode),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register; refilled in the cycle the held result transfers.
    assign w_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
            if (w_res_valid) begin
                r_m_res <= w_res;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_res.entry_count, r_m_res.top_value};
    assign o_m_tuser  = r_m_res.status;

    // A full-store rejection only happens at capacity.
    `BHPQ_ASSERT_SAME(a_full_at_capacity, o_m_tvalid && r_m_res.status == bhpq_pkg::ST_FULL,
        r_m_res.entry_count == bhpq_pkg::ENTRY_W'(bhpq_pkg::CAPACITY))
    // An empty queue reports -1 on top.
    `BHPQ_ASSERT_SAME(a_empty_top, o_m_tvalid && r_m_res.entry_count == '0,
        r_m_res.top_value == '1)
    // A removal on empty leaves the count at zero.
    `BHPQ_ASSERT_SAME(a_empty_remove, o_m_tvalid && r_m_res.status == bhpq_pkg::ST_EMPTY,
        r_m_res.entry_count == '0)
    // Once an item is taken, the engine is busy in the next cycle.
    `BHPQ_ASSERT_NEXT(a_busy_after_accept, w_in_xfer, !o_s_tready)

endmodule

`default_nettype wire
